// ===== rtl/shape_pair_overlap_resolver_macros.svh =====
// Assertion macros for the shape pair overlap resolver.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SHAPE_PAIR_OVERLAP_RESOLVER_MACROS_SVH
`define SHAPE_PAIR_OVERLAP_RESOLVER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define SPOR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define SPOR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/spor_pkg.sv =====
// Shared widths, stage indexes, types and helper functions of the shape pair resolver.
// No dependencies.
`timescale 1ns / 1ps

package spor_pkg;

   // coordinate and derived widths
   localparam int CW         = 24;
   localparam int HW         = CW - 1;
   localparam int EW         = CW + 1;
   localparam int DW         = CW + 2;
   localparam int FW         = CW + 3;
   localparam int SQW        = 2 * CW;
   localparam int UW         = 16;
   localparam int UNIT_SHIFT = 14;
   localparam int UNIT_ONE   = 1 << UNIT_SHIFT;

   // pipeline layout
   localparam int RT_STEPS = CW;
   localparam int DV_STEPS = CW;
   localparam int ST_SQ0   = 6;
   localparam int ST_PEN   = ST_SQ0 + RT_STEPS;
   localparam int ST_MUL   = ST_PEN + 1;
   localparam int ST_DV0   = ST_MUL + 1;
   localparam int ST_LAST  = ST_DV0 + DV_STEPS - 1;

   // divider lanes
   localparam int LANES   = 4;
   localparam int LANE_PX = 0;
   localparam int LANE_PY = 1;
   localparam int LANE_UX = 2;
   localparam int LANE_UY = 3;

   // {a_is_rect, b_is_rect}
   typedef enum logic [1:0] {
      PAIR_CC = 2'b00,
      PAIR_CR = 2'b01,
      PAIR_RC = 2'b10,
      PAIR_RR = 2'b11
   } pair_type;

   // side data that travels with an item down the pipeline
   typedef struct packed {
      logic                 moved;
      logic                 is_round;
      logic                 is_cc;
      logic                 ov;
      logic                 zero;
      logic                 sx;
      logic                 sy;
      logic signed [FW-1:0] fpx;
      logic signed [FW-1:0] fpy;
   } carry_type;

   function automatic logic signed [FW-1:0] e2f(input logic signed [EW-1:0] v);
      return {{(FW-EW){v[EW-1]}}, v};
   endfunction

   function automatic logic signed [FW-1:0] c2f(input logic signed [CW-1:0] v);
      return {{(FW-CW){v[CW-1]}}, v};
   endfunction

   function automatic logic signed [FW-1:0] h2f(input logic [HW-1:0] v);
      return {{(FW-HW){1'b0}}, v};
   endfunction

   function automatic logic [DW-1:0] abs_dw(input logic signed [DW-1:0] v);
      logic signed [DW-1:0] n;
      n = -v;
      return v[DW-1] ? n : v;
   endfunction

   function automatic logic [FW-1:0] abs_fw(input logic signed [FW-1:0] v);
      logic signed [FW-1:0] n;
      n = -v;
      return v[FW-1] ? n : v;
   endfunction

   // clamp to the signed coordinate range
   function automatic logic signed [CW-1:0] sat_coord(input logic signed [FW-1:0] v);
      logic signed [FW-1:0] hi;
      logic signed [FW-1:0] lo;
      hi = {{(FW-CW+1){1'b0}}, {(CW-1){1'b1}}};
      lo = {{(FW-CW+1){1'b1}}, {(CW-1){1'b0}}};
      if (v > hi) begin
         return hi[CW-1:0];
      end else if (v < lo) begin
         return lo[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

endpackage

// ===== rtl/shape_pair_overlap_resolver.sv =====
// Shape pair overlap resolver top level: geometry, squares, square root, dividers, output.
// Depends on spor_pkg and shape_pair_overlap_resolver_macros.svh.
//
//   channel | direction | ports             | handshake
//   --------+-----------+-------------------+----------------------------
//   request | in        | req_a_*, req_b_*  | req_valid / req_ready
//   result  | out       | rsp_*             | rsp_valid / rsp_ready
//
// One pair enters per cycle while no stall holds the pipeline.
// Most of the pipeline is the 24-stage square root and the 24-stage restoring dividers.
// Reset clears the stage valid bits and the output valid; payload registers keep junk.
// While rsp_valid is high and rsp_ready low, the whole pipeline holds and req_ready is low.
`timescale 1ns / 1ps
`include "shape_pair_overlap_resolver_macros.svh"

module shape_pair_overlap_resolver (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_a_is_rect,
   input  logic signed [spor_pkg::CW-1:0]  req_a_cx,
   input  logic signed [spor_pkg::CW-1:0]  req_a_cy,
   input  logic        [spor_pkg::HW-1:0]  req_a_half_w,
   input  logic        [spor_pkg::HW-1:0]  req_a_half_h,
   input  logic                            req_b_is_rect,
   input  logic signed [spor_pkg::CW-1:0]  req_b_cx,
   input  logic signed [spor_pkg::CW-1:0]  req_b_cy,
   input  logic        [spor_pkg::HW-1:0]  req_b_half_w,
   input  logic        [spor_pkg::HW-1:0]  req_b_half_h,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_overlapping,
   output logic                            rsp_moved_is_b,
   output logic signed [spor_pkg::CW-1:0]  rsp_push_dx,
   output logic signed [spor_pkg::CW-1:0]  rsp_push_dy,
   output logic signed [spor_pkg::UW-1:0]  rsp_unit_dx,
   output logic signed [spor_pkg::UW-1:0]  rsp_unit_dy
);
   import spor_pkg::*;

   logic adv;
   logic v_ff [1:ST_LAST];
   carry_type car_ff [3:ST_LAST];
   carry_type car_in [3:5];

   // stage 1: edges and circle sums
   pair_type s1_pair_ff, s1_pair_in;
   logic signed [EW-1:0] s1_al_ff, s1_ar_ff, s1_at_ff, s1_ab_ff;
   logic signed [EW-1:0] s1_bl_ff, s1_br_ff, s1_bt_ff, s1_bb_ff;
   logic signed [EW-1:0] s1_al_in, s1_ar_in, s1_at_in, s1_ab_in;
   logic signed [EW-1:0] s1_bl_in, s1_br_in, s1_bt_in, s1_bb_in;
   logic signed [CW-1:0] s1_acx_ff, s1_acy_ff, s1_bcx_ff, s1_bcy_ff;
   logic [HW-1:0]        s1_ahw_ff, s1_bhw_ff;
   logic signed [EW-1:0] s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic [CW-1:0]        s1_rs_ff, s1_rs_in;

   // stage 2: unified round and face operands
   logic                 s2_round_ff, s2_round_in, s2_cc_ff, s2_cc_in, s2_moved_ff, s2_moved_in;
   logic                 s2_fov_ff, s2_fov_in;
   logic signed [DW-1:0] s2_dx_ff, s2_dy_ff, s2_dx_in, s2_dy_in;
   logic [CW-1:0]        s2_rs_ff, s2_rs_in;
   logic signed [FW-1:0] s2_fl_ff, s2_fr_ff, s2_ft_ff, s2_fb_ff;
   logic signed [FW-1:0] s2_fl_in, s2_fr_in, s2_ft_in, s2_fb_in;

   // stage 3 and 4: magnitudes, squares
   logic [CW-1:0]  s3_ax_ff, s3_ay_ff, s3_rs_ff, s3_ax_in, s3_ay_in;
   logic [CW-1:0]  s4_ax_ff, s4_ay_ff, s4_rs_ff;
   logic [SQW-1:0] s4_x2_ff, s4_y2_ff, s4_r2_ff;
   logic [SQW:0]   s5_d2;

   // square root chain
   logic [SQW-1:0] sq_rem_ff [0:RT_STEPS];
   logic [SQW-1:0] sq_rem_in [1:RT_STEPS];
   logic [CW-1:0]  sq_root_ff [0:RT_STEPS];
   logic [CW-1:0]  sq_root_in [1:RT_STEPS];
   logic [CW-1:0]  sq_ax_ff [0:RT_STEPS];
   logic [CW-1:0]  sq_ay_ff [0:RT_STEPS];
   logic [CW-1:0]  sq_rs_ff [0:RT_STEPS];

   // penetration depth
   logic [CW-1:0] pn_pen_ff, pn_den_ff, pn_ax_ff, pn_ay_ff;

   // divider chain
   logic [SQW-1:0] dv_rem_ff [0:LANES-1][0:DV_STEPS];
   logic [SQW-1:0] dv_rem_in [0:LANES-1][1:DV_STEPS];
   logic [CW-1:0]  dv_q_ff [0:LANES-1][0:DV_STEPS];
   logic [CW-1:0]  dv_q_in [0:LANES-1][1:DV_STEPS];
   logic [CW-1:0]  dv_den_ff [0:DV_STEPS];

   // output
   logic                 rsp_valid_ff;
   logic                 ov_ff, ov_in, mv_ff, mv_in;
   logic signed [CW-1:0] pdx_ff, pdy_ff, pdx_in, pdy_in;
   logic signed [UW-1:0] udx_ff, udy_ff, udx_in, udy_in;
   logic signed [FW-1:0] ln_push [0:LANES-1];
   logic signed [UW-1:0] ln_unit [0:LANES-1];

   // advance whenever the output register is free or being drained
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage 1: per-shape edges, circle difference and radius sum
   always_comb begin
      s1_pair_in = pair_type'({req_a_is_rect, req_b_is_rect});
      s1_al_in = $signed({req_a_cx[CW-1], req_a_cx}) - $signed({2'b00, req_a_half_w});
      s1_ar_in = $signed({req_a_cx[CW-1], req_a_cx}) + $signed({2'b00, req_a_half_w});
      s1_at_in = $signed({req_a_cy[CW-1], req_a_cy}) - $signed({2'b00, req_a_half_h});
      s1_ab_in = $signed({req_a_cy[CW-1], req_a_cy}) + $signed({2'b00, req_a_half_h});
      s1_bl_in = $signed({req_b_cx[CW-1], req_b_cx}) - $signed({2'b00, req_b_half_w});
      s1_br_in = $signed({req_b_cx[CW-1], req_b_cx}) + $signed({2'b00, req_b_half_w});
      s1_bt_in = $signed({req_b_cy[CW-1], req_b_cy}) - $signed({2'b00, req_b_half_h});
      s1_bb_in = $signed({req_b_cy[CW-1], req_b_cy}) + $signed({2'b00, req_b_half_h});
      s1_dx_in = $signed({req_a_cx[CW-1], req_a_cx}) - $signed({req_b_cx[CW-1], req_b_cx});
      s1_dy_in = $signed({req_a_cy[CW-1], req_a_cy}) - $signed({req_b_cy[CW-1], req_b_cy});
      s1_rs_in = {1'b0, req_a_half_w} + {1'b0, req_b_half_w};
   end

   // stage 2: pick the path, clamp the circle center for mixed pairs
   always_comb begin
      logic signed [EW-1:0] m_l, m_r, m_t, m_b, m_cx, m_cy;
      logic [HW-1:0]        m_p;
      logic signed [DW-1:0] m_dx, m_dy;
      logic                 m_in;
      if (s1_pair_ff == PAIR_RC) begin
         m_l = s1_al_ff; m_r = s1_ar_ff; m_t = s1_at_ff; m_b = s1_ab_ff;
         m_cx = {s1_bcx_ff[CW-1], s1_bcx_ff}; m_cy = {s1_bcy_ff[CW-1], s1_bcy_ff};
         m_p = s1_bhw_ff;
      end else begin
         m_l = s1_bl_ff; m_r = s1_br_ff; m_t = s1_bt_ff; m_b = s1_bb_ff;
         m_cx = {s1_acx_ff[CW-1], s1_acx_ff}; m_cy = {s1_acy_ff[CW-1], s1_acy_ff};
         m_p = s1_ahw_ff;
      end
      if (m_cx < m_l) begin
         m_dx = $signed({m_cx[EW-1], m_cx}) - $signed({m_l[EW-1], m_l});
      end else if (m_cx > m_r) begin
         m_dx = $signed({m_cx[EW-1], m_cx}) - $signed({m_r[EW-1], m_r});
      end else begin
         m_dx = '0;
      end
      if (m_cy < m_t) begin
         m_dy = $signed({m_cy[EW-1], m_cy}) - $signed({m_t[EW-1], m_t});
      end else if (m_cy > m_b) begin
         m_dy = $signed({m_cy[EW-1], m_cy}) - $signed({m_b[EW-1], m_b});
      end else begin
         m_dy = '0;
      end
      m_in = (m_dx == '0) && (m_dy == '0);

      s2_moved_in = (s1_pair_ff == PAIR_RC);
      s2_cc_in    = (s1_pair_ff == PAIR_CC);
      s2_dx_in    = {s1_dx_ff[EW-1], s1_dx_ff};
      s2_dy_in    = {s1_dy_ff[EW-1], s1_dy_ff};
      s2_rs_in    = s1_rs_ff;
      s2_fl_in    = e2f(s1_ar_ff) - e2f(s1_bl_ff);
      s2_fr_in    = e2f(s1_br_ff) - e2f(s1_al_ff);
      s2_ft_in    = e2f(s1_ab_ff) - e2f(s1_bt_ff);
      s2_fb_in    = e2f(s1_bb_ff) - e2f(s1_at_ff);
      s2_round_in = 1'b0;
      s2_fov_in   = 1'b0;
      case (s1_pair_ff) inside
         PAIR_CC: begin
            s2_round_in = 1'b1;
         end
         PAIR_RR: begin
            s2_fov_in = (s2_fl_in > 0) && (s2_fr_in > 0) && (s2_ft_in > 0) && (s2_fb_in > 0);
         end
         PAIR_CR, PAIR_RC: begin
            s2_round_in = !m_in;
            s2_fov_in   = (m_p != '0);
            s2_dx_in    = m_dx;
            s2_dy_in    = m_dy;
            s2_rs_in    = {1'b0, m_p};
            s2_fl_in    = e2f(m_cx) - e2f(m_l) + h2f(m_p);
            s2_fr_in    = e2f(m_r) - e2f(m_cx) + h2f(m_p);
            s2_ft_in    = e2f(m_cy) - e2f(m_t) + h2f(m_p);
            s2_fb_in    = e2f(m_b) - e2f(m_cy) + h2f(m_p);
         end
         default: begin
            s2_round_in = 1'b0;
         end
      endcase
   end

   // stage 3: magnitudes, early reject, face candidates
   always_comb begin
      logic [DW-1:0] ax, ay;
      logic          big;
      ax  = abs_dw(s2_dx_ff);
      ay  = abs_dw(s2_dy_ff);
      big = (ax >= {{(DW-CW){1'b0}}, s2_rs_ff}) || (ay >= {{(DW-CW){1'b0}}, s2_rs_ff});
      s3_ax_in           = ax[CW-1:0];
      s3_ay_in           = ay[CW-1:0];
      car_in[3].moved    = s2_moved_ff;
      car_in[3].is_round = s2_round_ff;
      car_in[3].is_cc    = s2_cc_ff;
      car_in[3].ov       = s2_round_ff ? !big : s2_fov_ff;
      car_in[3].zero     = 1'b0;
      car_in[3].sx       = s2_dx_ff[DW-1];
      car_in[3].sy       = s2_dy_ff[DW-1];
      car_in[3].fpx      = (s2_fl_ff < s2_fr_ff) ? -s2_fl_ff : s2_fr_ff;
      car_in[3].fpy      = (s2_ft_ff < s2_fb_ff) ? -s2_ft_ff : s2_fb_ff;
   end

   // stage 4: keep the face axis with the smaller push
   always_comb begin
      car_in[4] = car_ff[3];
      if (abs_fw(car_ff[3].fpx) < abs_fw(car_ff[3].fpy)) begin
         car_in[4].fpy = '0;
      end else begin
         car_in[4].fpx = '0;
      end
   end

   // stage 5: squared distance against squared radius sum
   always_comb begin
      s5_d2     = {1'b0, s4_x2_ff} + {1'b0, s4_y2_ff};
      car_in[5] = car_ff[4];
      if (car_ff[4].is_round) begin
         car_in[5].ov = car_ff[4].ov && (s5_d2 < {1'b0, s4_r2_ff});
      end
      car_in[5].zero = (s5_d2 == '0);
   end

   // square root: one result bit per stage
   for (genvar k = 0; k < RT_STEPS; k++) begin : g_sqrt
      localparam int BI = CW - 1 - k;
      logic [SQW-1:0] trial;
      logic           ge;
      assign trial = ({{(SQW-CW){1'b0}}, sq_root_ff[k]} << (BI + 1)) | (SQW'(1) << (2 * BI));
      assign ge    = (sq_rem_ff[k] >= trial);
      assign sq_rem_in[k+1]  = ge ? (sq_rem_ff[k] - trial) : sq_rem_ff[k];
      assign sq_root_in[k+1] = ge ? (sq_root_ff[k] | (CW'(1) << BI)) : sq_root_ff[k];
   end

   // restoring division: one quotient bit per stage, four lanes share the divisor
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      for (genvar k = 0; k < DV_STEPS; k++) begin : g_step
         localparam int BJ = CW - 1 - k;
         logic [SQW-1:0] sub;
         logic           ge;
         assign sub = {{(SQW-CW){1'b0}}, dv_den_ff[k]} << BJ;
         assign ge  = (dv_rem_ff[l][k] >= sub);
         assign dv_rem_in[l][k+1] = ge ? (dv_rem_ff[l][k] - sub) : dv_rem_ff[l][k];
         assign dv_q_in[l][k+1]   = ge ? (dv_q_ff[l][k] | (CW'(1) << BJ)) : dv_q_ff[l][k];
      end

      // round half away from zero, then apply the sign
      logic                 rnd;
      logic [CW:0]          qr;
      logic signed [FW-1:0] qf;
      logic                 sgn;
      logic [UW-1:0]        um;
      assign rnd = ({dv_rem_ff[l][DV_STEPS], 1'b0} >=
                    {{(SQW-CW+1){1'b0}}, dv_den_ff[DV_STEPS]});
      assign qr  = {1'b0, dv_q_ff[l][DV_STEPS]} + {{CW{1'b0}}, rnd};
      assign qf  = {{(FW-CW-1){1'b0}}, qr};
      assign sgn = (l == LANE_PX || l == LANE_UX) ? car_ff[ST_LAST].sx : car_ff[ST_LAST].sy;
      assign um  = qr[UW-1:0];
      assign ln_push[l] = sgn ? -qf : qf;
      assign ln_unit[l] = sgn ? -um : um;
   end

   // output selection
   always_comb begin
      carry_type c;
      c      = car_ff[ST_LAST];
      ov_in  = c.ov;
      mv_in  = c.moved;
      pdx_in = '0;
      pdy_in = '0;
      udx_in = '0;
      udy_in = '0;
      if (c.ov) begin
         if (!c.is_round) begin
            pdx_in = sat_coord(c.fpx);
            pdy_in = sat_coord(c.fpy);
         end else if (!c.zero) begin
            pdx_in = sat_coord(ln_push[LANE_PX]);
            pdy_in = sat_coord(ln_push[LANE_PY]);
            if (c.is_cc) begin
               udx_in = ln_unit[LANE_UX];
               udy_in = ln_unit[LANE_UY];
            end
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= ST_LAST; s++) begin
            v_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff[1] <= req_valid;
         for (int s = 2; s <= ST_LAST; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
         rsp_valid_ff <= v_ff[ST_LAST];
      end
   end

   // payload registers: hold on stall, advance otherwise
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pair_ff <= s1_pair_in;
         s1_al_ff <= s1_al_in; s1_ar_ff <= s1_ar_in; s1_at_ff <= s1_at_in; s1_ab_ff <= s1_ab_in;
         s1_bl_ff <= s1_bl_in; s1_br_ff <= s1_br_in; s1_bt_ff <= s1_bt_in; s1_bb_ff <= s1_bb_in;
         s1_acx_ff <= req_a_cx; s1_acy_ff <= req_a_cy;
         s1_bcx_ff <= req_b_cx; s1_bcy_ff <= req_b_cy;
         s1_ahw_ff <= req_a_half_w; s1_bhw_ff <= req_b_half_w;
         s1_dx_ff <= s1_dx_in; s1_dy_ff <= s1_dy_in; s1_rs_ff <= s1_rs_in;

         s2_round_ff <= s2_round_in; s2_cc_ff <= s2_cc_in; s2_moved_ff <= s2_moved_in;
         s2_fov_ff <= s2_fov_in; s2_dx_ff <= s2_dx_in; s2_dy_ff <= s2_dy_in;
         s2_rs_ff <= s2_rs_in;
         s2_fl_ff <= s2_fl_in; s2_fr_ff <= s2_fr_in; s2_ft_ff <= s2_ft_in; s2_fb_ff <= s2_fb_in;

         s3_ax_ff <= s3_ax_in; s3_ay_ff <= s3_ay_in; s3_rs_ff <= s2_rs_ff;

         s4_ax_ff <= s3_ax_ff; s4_ay_ff <= s3_ay_ff; s4_rs_ff <= s3_rs_ff;
         s4_x2_ff <= s3_ax_ff * s3_ax_ff;
         s4_y2_ff <= s3_ay_ff * s3_ay_ff;
         s4_r2_ff <= s3_rs_ff * s3_rs_ff;

         for (int s = 3; s <= 5; s++) begin
            car_ff[s] <= car_in[s];
         end
         for (int s = 6; s <= ST_LAST; s++) begin
            car_ff[s] <= car_ff[s-1];
         end

         sq_rem_ff[0]  <= s5_d2[SQW-1:0];
         sq_root_ff[0] <= '0;
         sq_ax_ff[0]   <= s4_ax_ff;
         sq_ay_ff[0]   <= s4_ay_ff;
         sq_rs_ff[0]   <= s4_rs_ff;
         for (int k = 1; k <= RT_STEPS; k++) begin
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
            sq_ax_ff[k]   <= sq_ax_ff[k-1];
            sq_ay_ff[k]   <= sq_ay_ff[k-1];
            sq_rs_ff[k]   <= sq_rs_ff[k-1];
         end

         pn_pen_ff <= sq_rs_ff[RT_STEPS] - sq_root_ff[RT_STEPS];
         pn_den_ff <= sq_root_ff[RT_STEPS];
         pn_ax_ff  <= sq_ax_ff[RT_STEPS];
         pn_ay_ff  <= sq_ay_ff[RT_STEPS];

         dv_rem_ff[LANE_PX][0] <= pn_ax_ff * pn_pen_ff;
         dv_rem_ff[LANE_PY][0] <= pn_ay_ff * pn_pen_ff;
         dv_rem_ff[LANE_UX][0] <= {{(SQW-CW){1'b0}}, pn_ax_ff} << UNIT_SHIFT;
         dv_rem_ff[LANE_UY][0] <= {{(SQW-CW){1'b0}}, pn_ay_ff} << UNIT_SHIFT;
         dv_den_ff[0] <= pn_den_ff;
         for (int l = 0; l < LANES; l++) begin
            dv_q_ff[l][0] <= '0;
            for (int k = 1; k <= DV_STEPS; k++) begin
               dv_rem_ff[l][k] <= dv_rem_in[l][k];
               dv_q_ff[l][k]   <= dv_q_in[l][k];
            end
         end
         for (int k = 1; k <= DV_STEPS; k++) begin
            dv_den_ff[k] <= dv_den_ff[k-1];
         end

         ov_ff  <= ov_in;
         mv_ff  <= mv_in;
         pdx_ff <= pdx_in;
         pdy_ff <= pdy_in;
         udx_ff <= udx_in;
         udy_ff <= udy_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_overlapping = ov_ff;
   assign rsp_moved_is_b  = mv_ff;
   assign rsp_push_dx     = pdx_ff;
   assign rsp_push_dy     = pdy_ff;
   assign rsp_unit_dx     = udx_ff;
   assign rsp_unit_dy     = udy_ff;

   // a result without overlap moves nothing
   `SPOR_ASSERT_SAME(a_no_ov_zero, clock, reset, rsp_valid && !rsp_overlapping,
      rsp_push_dx == '0 && rsp_push_dy == '0 && rsp_unit_dx == '0 && rsp_unit_dy == '0,
      "push or unit nonzero without overlap")
   // a unit direction only comes from an overlapping circle pair, which moves A
   `SPOR_ASSERT_SAME(a_unit_cc, clock, reset,
      rsp_valid && (rsp_unit_dx != '0 || rsp_unit_dy != '0),
      rsp_overlapping && !rsp_moved_is_b, "unit direction outside a circle pair")
   // unit components stay within one
   `SPOR_ASSERT_SAME(a_unit_range, clock, reset, rsp_valid,
      rsp_unit_dx <= $signed(UW'(UNIT_ONE)) && rsp_unit_dx >= -$signed(UW'(UNIT_ONE)) &&
      rsp_unit_dy <= $signed(UW'(UNIT_ONE)) && rsp_unit_dy >= -$signed(UW'(UNIT_ONE)),
      "unit component beyond one")
   // a stall keeps the item in the last stage
   `SPOR_ASSERT_NEXT(a_stall_hold, clock, reset, v_ff[ST_LAST] && !adv, v_ff[ST_LAST],
      "last stage item lost during stall")

endmodule

// ===== tb/shape_pair_checker.sv =====
// Result checker for the shape pair overlap resolver: watches both channels,
// predicts each result from the accepted pair and compares in order. Needs no package.
`timescale 1ns / 1ps

module shape_pair_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_a_is_rect,
   input  logic signed [23:0] req_a_cx,
   input  logic signed [23:0] req_a_cy,
   input  logic        [22:0] req_a_half_w,
   input  logic        [22:0] req_a_half_h,
   input  logic               req_b_is_rect,
   input  logic signed [23:0] req_b_cx,
   input  logic signed [23:0] req_b_cy,
   input  logic        [22:0] req_b_half_w,
   input  logic        [22:0] req_b_half_h,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_overlapping,
   input  logic               rsp_moved_is_b,
   input  logic signed [23:0] rsp_push_dx,
   input  logic signed [23:0] rsp_push_dy,
   input  logic signed [15:0] rsp_unit_dx,
   input  logic signed [15:0] rsp_unit_dy,
   output int                 errors,
   output int                 pending,
   output int                 resolved_count,
   output int                 overlap_count
);

   localparam longint unsigned UNIT_ONE = 16384;

   typedef struct packed {
      logic               ov;
      logic               moved;
      logic signed [23:0] pdx;
      logic signed [23:0] pdy;
      logic signed [15:0] udx;
      logic signed [15:0] udy;
   } resolution_type;

   resolution_type expected_q[$];

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   // floor square root, one result bit per pass
   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // d * k / den rounded to nearest, ties away from zero
   function automatic longint scaled_round(longint d, longint unsigned k,
                                           longint unsigned den);
      longint unsigned p;
      longint unsigned q;
      longint unsigned r;
      p = magnitude(d) * k;
      q = p / den;
      r = p % den;
      if (r >= den - r) q = q + 1;
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp_coord(longint v);
      return v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v);
   endfunction

   function automatic longint clamp_range(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // round separation: overlap test plus push and unit vectors
   function automatic bit round_push(longint dx, longint dy, longint unsigned rsum,
                                     output longint px, output longint py,
                                     output longint ux, output longint uy);
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned d2;
      longint unsigned len;
      px = 0; py = 0; ux = 0; uy = 0;
      ax = magnitude(dx);
      ay = magnitude(dy);
      if (ax >= rsum || ay >= rsum) return 0;
      if (ay * ay >= rsum * rsum - ax * ax) return 0;
      d2 = ax * ax + ay * ay;
      if (d2 == 0) return 1;
      len = root_floor(d2);
      px = scaled_round(dx, rsum - len, len);
      py = scaled_round(dy, rsum - len, len);
      ux = scaled_round(dx, UNIT_ONE, len);
      uy = scaled_round(dy, UNIT_ONE, len);
      return 1;
   endfunction

   // leave along the axis of least penetration; ties go to y
   function automatic void face_push(longint l, longint r, longint t, longint b,
                                     output longint px, output longint py);
      longint x;
      longint y;
      x = l < r ? -l : r;
      y = t < b ? -t : b;
      if (magnitude(x) < magnitude(y)) y = 0;
      else x = 0;
      px = x;
      py = y;
   endfunction

   function automatic resolution_type resolve_pair();
      resolution_type res;
      longint acx, acy, ahw, ahh, bcx, bcy, bhw, bhh;
      longint px, py, ux, uy, dux, duy;
      longint rx, ry, rw, rh, cx, cy, p, el, er, et, eb, fx, fy;
      bit ov;
      bit moved;
      acx = req_a_cx; acy = req_a_cy; ahw = req_a_half_w; ahh = req_a_half_h;
      bcx = req_b_cx; bcy = req_b_cy; bhw = req_b_half_w; bhh = req_b_half_h;
      px = 0; py = 0; ux = 0; uy = 0;
      ov = 0;
      moved = 0;
      if (!req_a_is_rect && !req_b_is_rect) begin
         ov = round_push(acx - bcx, acy - bcy, ahw + bhw, px, py, ux, uy);
      end else if (req_a_is_rect && req_b_is_rect) begin
         el = (acx + ahw) - (bcx - bhw);
         er = (bcx + bhw) - (acx - ahw);
         et = (acy + ahh) - (bcy - bhh);
         eb = (bcy + bhh) - (acy - ahh);
         if (el > 0 && er > 0 && et > 0 && eb > 0) begin
            ov = 1;
            face_push(el, er, et, eb, px, py);
         end
      end else begin
         // mixed pair: the circle moves
         if (req_a_is_rect) begin
            moved = 1;
            rx = acx; ry = acy; rw = ahw; rh = ahh; cx = bcx; cy = bcy; p = bhw;
         end else begin
            rx = bcx; ry = bcy; rw = bhw; rh = bhh; cx = acx; cy = acy; p = ahw;
         end
         el = rx - rw; er = rx + rw; et = ry - rh; eb = ry + rh;
         fx = clamp_range(cx, el, er);
         fy = clamp_range(cy, et, eb);
         if (fx == cx && fy == cy) begin
            if (p > 0) begin
               ov = 1;
               face_push(cx - el + p, er - cx + p, cy - et + p, eb - cy + p, px, py);
            end
         end else begin
            ov = round_push(cx - fx, cy - fy, p, px, py, dux, duy);
         end
      end
      if (!ov) begin
         px = 0; py = 0; ux = 0; uy = 0;
      end
      res.ov = ov;
      res.moved = moved;
      res.pdx = 24'(clamp_coord(px));
      res.pdy = 24'(clamp_coord(py));
      res.udx = ux[15:0];
      res.udy = uy[15:0];
      return res;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
         errors++;
      end
   endtask

   initial begin
      errors = 0;
      pending = 0;
      resolved_count = 0;
      overlap_count = 0;
   end

   // compare the result transfer first, then log the new request transfer
   always @(posedge clock) begin
      resolution_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: result with no pair outstanding, actual ov=%0b dx=%0d dy=%0d",
                        $realtime, rsp_overlapping, rsp_push_dx, rsp_push_dy);
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("overlapping", want.ov, rsp_overlapping);
               check_field("moved_is_b", want.moved, rsp_moved_is_b);
               check_field("push_dx", want.pdx, rsp_push_dx);
               check_field("push_dy", want.pdy, rsp_push_dy);
               check_field("unit_dx", want.udx, rsp_unit_dx);
               check_field("unit_dy", want.udy, rsp_unit_dy);
               resolved_count++;
               if (want.ov) overlap_count++;
            end
         end
         if (req_valid && req_ready) expected_q.push_back(resolve_pair());
         pending = expected_q.size();
      end
   end

endmodule

// ===== tb/tb_shape_pair_overlap_resolver.sv =====
// Testbench top for the shape pair overlap resolver: clock, reset, pair stimulus,
// handshake idling and verdict. Depends on spor_pkg, the block and shape_pair_checker.
`timescale 1ns / 1ps

module tb_shape_pair_overlap_resolver;
   import spor_pkg::*;

   typedef struct packed {
      logic                 a_rect;
      logic signed [CW-1:0] a_cx;
      logic signed [CW-1:0] a_cy;
      logic        [HW-1:0] a_w;
      logic        [HW-1:0] a_h;
      logic                 b_rect;
      logic signed [CW-1:0] b_cx;
      logic signed [CW-1:0] b_cy;
      logic        [HW-1:0] b_w;
      logic        [HW-1:0] b_h;
   } shape_pair_type;

   localparam int RANDOM_PAIRS = 1130;
   localparam int MAX_C = 8388607;
   localparam int MIN_C = -8388608;
   localparam int PAIR_BITS = $bits(shape_pair_type);

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   shape_pair_type pair;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_overlapping;
   logic rsp_moved_is_b;
   logic signed [CW-1:0] rsp_push_dx;
   logic signed [CW-1:0] rsp_push_dy;
   logic signed [UW-1:0] rsp_unit_dx;
   logic signed [UW-1:0] rsp_unit_dy;
   int errors;
   int pending;
   int resolved_count;
   int overlap_count;
   int send_idle_pct;
   int recv_idle_pct;
   int sent_count;

   shape_pair_overlap_resolver uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_is_rect(pair.a_rect), .req_a_cx(pair.a_cx), .req_a_cy(pair.a_cy),
      .req_a_half_w(pair.a_w), .req_a_half_h(pair.a_h),
      .req_b_is_rect(pair.b_rect), .req_b_cx(pair.b_cx), .req_b_cy(pair.b_cy),
      .req_b_half_w(pair.b_w), .req_b_half_h(pair.b_h),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_overlapping(rsp_overlapping), .rsp_moved_is_b(rsp_moved_is_b),
      .rsp_push_dx(rsp_push_dx), .rsp_push_dy(rsp_push_dy),
      .rsp_unit_dx(rsp_unit_dx), .rsp_unit_dy(rsp_unit_dy)
   );

   shape_pair_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_is_rect(pair.a_rect), .req_a_cx(pair.a_cx), .req_a_cy(pair.a_cy),
      .req_a_half_w(pair.a_w), .req_a_half_h(pair.a_h),
      .req_b_is_rect(pair.b_rect), .req_b_cx(pair.b_cx), .req_b_cy(pair.b_cy),
      .req_b_half_w(pair.b_w), .req_b_half_h(pair.b_h),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_overlapping(rsp_overlapping), .rsp_moved_is_b(rsp_moved_is_b),
      .rsp_push_dx(rsp_push_dx), .rsp_push_dy(rsp_push_dy),
      .rsp_unit_dx(rsp_unit_dx), .rsp_unit_dy(rsp_unit_dy),
      .errors(errors), .pending(pending),
      .resolved_count(resolved_count), .overlap_count(overlap_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // randomly withhold ready on the result side
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
   end

   function automatic shape_pair_type make_pair(logic ar, int ax, int ay, int aw, int ah,
                                                logic br, int bx, int by, int bw, int bh);
      shape_pair_type s;
      s.a_rect = ar; s.a_cx = CW'(ax); s.a_cy = CW'(ay); s.a_w = HW'(aw); s.a_h = HW'(ah);
      s.b_rect = br; s.b_cx = CW'(bx); s.b_cy = CW'(by); s.b_w = HW'(bw); s.b_h = HW'(bh);
      return s;
   endfunction

   function automatic int near_offset(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // fill a whole pair with random bits
   function automatic shape_pair_type noise_pair();
      return shape_pair_type'(PAIR_BITS'({$urandom, $urandom, $urandom,
                                          $urandom, $urandom, $urandom}));
   endfunction

   // mostly nearby shapes of modest size so that overlaps are common
   function automatic shape_pair_type random_pair();
      shape_pair_type s;
      int mode;
      int bx;
      int by;
      int span;
      mode = $urandom_range(0, 19);
      if (mode == 0) begin
         s = noise_pair();
      end else if (mode == 1) begin
         // huge shapes near the coordinate edges: saturated pushes
         s.a_rect = 1'($urandom); s.b_rect = 1'($urandom);
         s.a_cx = CW'($urandom_range(0, 1) ? MAX_C - $urandom_range(0, 4096)
                                           : MIN_C + $urandom_range(0, 4096));
         s.a_cy = CW'($urandom); s.b_cx = CW'($urandom); s.b_cy = CW'($urandom);
         s.a_w = HW'(MAX_C - $urandom_range(0, 65535)); s.a_h = HW'($urandom);
         s.b_w = HW'($urandom); s.b_h = HW'(MAX_C - $urandom_range(0, 65535));
      end else begin
         span = (mode < 6) ? 64 : 3000;
         bx = int'($urandom_range(0, 8000000)) - 4000000;
         by = int'($urandom_range(0, 8000000)) - 4000000;
         s.a_rect = 1'($urandom); s.b_rect = 1'($urandom);
         s.b_cx = CW'(bx); s.b_cy = CW'(by);
         s.a_cx = CW'((mode == 2) ? bx : bx + near_offset(span));
         s.a_cy = CW'((mode == 2) ? by : by + near_offset(span));
         s.a_w = HW'($urandom_range(0, span)); s.a_h = HW'($urandom_range(0, span));
         s.b_w = HW'($urandom_range(0, span)); s.b_h = HW'($urandom_range(0, span));
      end
      return s;
   endfunction

   // hold the pair until it transfers, then maybe leave a gap
   task automatic send_pair(input shape_pair_type s);
      pair = s;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_count++;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 0;
         pair = noise_pair();
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   initial begin
      shape_pair_type directed[$];
      reset = 1;
      req_valid = 0;
      pair = '0;
      send_idle_pct = 21;
      recv_idle_pct = 52;
      sent_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // circles: overlap, touch, coincident, zero radii, far apart
      directed.push_back(make_pair(0, 100, 50, 200, 0, 0, 0, 0, 150, 0));
      directed.push_back(make_pair(0, 300, 0, 100, 0, 0, 0, 0, 200, 0));
      directed.push_back(make_pair(0, 77, -9, 10, 0, 0, 77, -9, 5, 0));
      directed.push_back(make_pair(0, 5, 5, 0, 0, 0, 5, 5, 0, 0));
      directed.push_back(make_pair(0, MAX_C, MAX_C, MAX_C, MAX_C, 0, MIN_C, MIN_C, MAX_C, 0));
      directed.push_back(make_pair(0, -1, 1, MAX_C, 0, 0, 1, -1, MAX_C, 0));
      // rectangles: x axis, y axis, equal penetration, edge contact, saturation
      directed.push_back(make_pair(1, 0, 0, 100, 100, 1, 150, 20, 100, 100));
      directed.push_back(make_pair(1, 0, 0, 100, 100, 1, 20, -150, 100, 100));
      directed.push_back(make_pair(1, 0, 0, 100, 100, 1, 50, 50, 100, 100));
      directed.push_back(make_pair(1, 0, 0, 100, 100, 1, 200, 0, 100, 100));
      directed.push_back(make_pair(1, MIN_C, MIN_C, MAX_C, MAX_C, 1, MAX_C, MAX_C,
                                   MAX_C, MAX_C));
      directed.push_back(make_pair(1, MAX_C, 0, MAX_C, MAX_C, 1, MIN_C, 0, MAX_C, MAX_C));
      // mixed: circle outside near face and corner, center inside, zero radius inside
      directed.push_back(make_pair(0, 250, 0, 100, 0, 1, 0, 0, 200, 200));
      directed.push_back(make_pair(1, 0, 0, 200, 200, 0, 250, 260, 100, 0));
      directed.push_back(make_pair(0, 10, -180, 50, 0, 1, 0, 0, 200, 200));
      directed.push_back(make_pair(1, 0, 0, 200, 200, 0, 0, 0, 0, 0));
      directed.push_back(make_pair(0, MAX_C, MIN_C, MAX_C, MAX_C, 1, MIN_C, MAX_C,
                                   MAX_C, MAX_C));
      directed.push_back(make_pair(1, MAX_C, MAX_C, MAX_C, MAX_C, 0, MIN_C, MIN_C, MAX_C,
                                   MAX_C));
      foreach (directed[i]) send_pair(directed[i]);

      // three idling phases over the random pairs
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if (i == RANDOM_PAIRS / 3) begin
            send_idle_pct = 52;
            recv_idle_pct = 21;
         end else if (i == 2 * RANDOM_PAIRS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_pair(random_pair());
      end
      req_valid = 0;

      // drain the pipeline
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d shape pairs, checked %0d results, %0d of them overlapping.",
               sent_count, resolved_count, overlap_count);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout with %0d results outstanding", pending);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
